[rtl/core/cizt_pkg.sv]
// ----------------------------------------------------------------------------
// cizt_pkg
// Shared types and constants of the conveyor item zone tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cizt_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int ID_W     = 8;
    localparam int KIND_W   = 4;
    localparam int ZONE_W   = 3;
    localparam int TICKET_W = 32;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [TICKET_W-1:0] TICKET_MAX = 32'hFFFF_FFFF;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_NEW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SENSOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EJECT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_TYPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_TYPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_ZONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_ZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EJECTED_ZONE = 3'd4;

    // one slot as seen on the read port
    typedef struct packed {
        logic                active;
        logic [ID_W-1:0]     ident;
        logic [KIND_W-1:0]   kind;
        logic [ZONE_W-1:0]   zone;
        logic [TICKET_W-1:0] ticket;
    } t_slot_entry;

    // update request for one slot
    typedef struct packed {
        logic                alloc;   // write all fields, set active
        logic                move;    // write zone only
        logic                free;    // clear active
        logic [IDX_W-1:0]    idx;
        logic [ID_W-1:0]     ident;
        logic [KIND_W-1:0]   kind;
        logic [ZONE_W-1:0]   zone;
        logic [TICKET_W-1:0] ticket;
    } t_slot_wr;

endpackage

`default_nettype wire

[rtl/core/cizt_slot_table.sv]
// ----------------------------------------------------------------------------
// cizt_slot_table
// Slot storage: active flags with reset, payload fields written on
// allocation, zone also on a move. One read index, one update per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cizt_slot_table
    import cizt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    output t_slot_entry            o_rd_entry,
    input  wire t_slot_wr          i_wr
);

    logic [SLOTS-1:0]    r_active;
    logic [ID_W-1:0]     r_ident  [SLOTS];
    logic [KIND_W-1:0]   r_kind   [SLOTS];
    logic [ZONE_W-1:0]   r_zone   [SLOTS];
    logic [TICKET_W-1:0] r_ticket [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            if (i_wr.alloc) begin
                r_active[i_wr.idx] <= 1'b1;
            end else if (i_wr.free) begin
                r_active[i_wr.idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.alloc) begin
            r_ident[i_wr.idx]  <= i_wr.ident;
            r_kind[i_wr.idx]   <= i_wr.kind;
            r_ticket[i_wr.idx] <= i_wr.ticket;
        end
        if (i_wr.alloc || i_wr.move) begin
            r_zone[i_wr.idx] <= i_wr.zone;
        end
    end

    always_comb begin
        o_rd_entry.active = r_active[i_rd_idx];
        o_rd_entry.ident  = r_ident[i_rd_idx];
        o_rd_entry.kind   = r_kind[i_rd_idx];
        o_rd_entry.zone   = r_zone[i_rd_idx];
        o_rd_entry.ticket = r_ticket[i_rd_idx];
    end

endmodule

`default_nettype wire

[rtl/core/conveyor_item_zone_tracker.sv]
// ----------------------------------------------------------------------------
// conveyor_item_zone_tracker
// Keeps conveyor items in a slot table; handles new item, sensor and
// ejection events, reporting at most one item per event.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | to block  | i_in_valid / o_in_stall  | i_mode, i_box_type, i_sensor_id
//  out     | from block| o_out_valid / i_out_stall| o_box_id, o_box_kind, o_zone
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  An event walks the table one slot per cycle through a single 32-bit ticket
//  comparator, then updates the chosen slot and reports in the final step.
//  The final step waits while a previous report is still stalled at the output.
//  Reset clears the active flags and the id and ticket counters and loads the
//  config registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module conveyor_item_zone_tracker
    import cizt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // event input
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [KIND_W-1:0]     i_box_type,
    input  wire logic [ZONE_W-1:0]     i_sensor_id,
    // report output
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ID_W-1:0]            o_box_id,
    output logic [KIND_W-1:0]          o_box_kind,
    output logic [ZONE_W-1:0]          o_zone,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [MODE_W-1:0]   r_mode;
    logic [KIND_W-1:0]   r_type;
    logic [ZONE_W-1:0]   r_sensor;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [TICKET_W-1:0] r_lowest, n_lowest;
    logic                r_free_found, n_free_found;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [ID_W-1:0]     r_id_ctr, n_id_ctr;
    logic [TICKET_W-1:0] r_ticket_ctr, n_ticket_ctr;

    logic [KIND_W-1:0]   r_none_type;
    logic [KIND_W-1:0]   r_unknown_type;
    logic [ZONE_W-1:0]   r_entry_zone;
    logic [ZONE_W-1:0]   r_discard_zone;
    logic [ZONE_W-1:0]   r_ejected_zone;

    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic [KIND_W-1:0]   r_out_kind, n_out_kind;
    logic [ZONE_W-1:0]   r_out_zone, n_out_zone;

    logic [IDX_W-1:0]    rd_idx;
    t_slot_entry         rd_entry;
    t_slot_wr            slot_wr;

    logic                in_xfer;
    logic                done_fire;
    logic                key_match;
    logic [ZONE_W-1:0]   dest_zone;
    logic [ID_W-1:0]     id_inc;
    logic                do_alloc;

    cizt_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry),
        .i_wr       (slot_wr)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // scan walks the table; the update step rereads the chosen slot
    assign rd_idx    = (r_state == ST_DONE) ? r_best_idx : r_idx;
    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign dest_zone = r_sensor + ZONE_W'(1);
    assign id_inc    = r_id_ctr + ID_W'(1);
    assign do_alloc  = done_fire && (r_mode == MODE_NEW) && r_free_found
                       && (r_type != r_none_type);

    always_comb begin
        case (r_mode)
            MODE_SENSOR: key_match = (rd_entry.zone == r_sensor);
            MODE_EJECT:  key_match = (rd_entry.kind == r_type);
            default:     key_match = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_lowest     = r_lowest;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_id_ctr     = r_id_ctr;
        n_ticket_ctr = r_ticket_ctr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_id     = r_out_id;
        n_out_kind   = r_out_kind;
        n_out_zone   = r_out_zone;
        slot_wr      = '0;
        slot_wr.idx  = r_best_idx;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state      = ST_SCAN;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_best_idx   = '0;
                    n_lowest     = TICKET_MAX;
                    n_free_found = 1'b0;
                    n_free_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (!rd_entry.active && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                // strict compare keeps the lowest index on equal tickets
                if (rd_entry.active && key_match && (rd_entry.ticket < r_lowest)) begin
                    n_found    = 1'b1;
                    n_best_idx = r_idx;
                    n_lowest   = rd_entry.ticket;
                end
                if (r_idx == IDX_W'(SLOTS - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    n_state = ST_IDLE;
                    case (r_mode)
                        MODE_NEW: begin
                            if (do_alloc) begin
                                n_id_ctr       = (id_inc == '0) ? ID_W'(1) : id_inc;
                                n_ticket_ctr   = r_ticket_ctr + TICKET_W'(1);
                                slot_wr.alloc  = 1'b1;
                                slot_wr.idx    = r_free_idx;
                                slot_wr.ident  = n_id_ctr;
                                slot_wr.kind   = r_type;
                                slot_wr.zone   = r_entry_zone;
                                slot_wr.ticket = n_ticket_ctr;
                                n_out_valid    = 1'b1;
                                n_out_id       = n_id_ctr;
                                n_out_kind     = r_type;
                                n_out_zone     = r_entry_zone;
                            end
                        end
                        MODE_SENSOR: begin
                            if (r_found) begin
                                slot_wr.move = 1'b1;
                                slot_wr.zone = dest_zone;
                                slot_wr.free = (dest_zone == r_discard_zone)
                                               && (rd_entry.kind == r_unknown_type);
                                n_out_valid  = 1'b1;
                                n_out_id     = rd_entry.ident;
                                n_out_kind   = rd_entry.kind;
                                n_out_zone   = dest_zone;
                            end
                        end
                        MODE_EJECT: begin
                            if (r_found) begin
                                slot_wr.free = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out_id     = rd_entry.ident;
                                n_out_kind   = rd_entry.kind;
                                n_out_zone   = r_ejected_zone;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_id_ctr     <= '0;
            r_ticket_ctr <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_id_ctr     <= n_id_ctr;
            r_ticket_ctr <= n_ticket_ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_lowest     <= n_lowest;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out_id     <= n_out_id;
        r_out_kind   <= n_out_kind;
        r_out_zone   <= n_out_zone;
        if (in_xfer) begin
            r_mode   <= i_mode;
            r_type   <= i_box_type;
            r_sensor <= i_sensor_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_none_type    <= KIND_W'(0);
            r_unknown_type <= KIND_W'(1);
            r_entry_zone   <= ZONE_W'(1);
            r_discard_zone <= ZONE_W'(4);
            r_ejected_zone <= ZONE_W'(5);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NONE_TYPE:    r_none_type    <= i_cfg_data[KIND_W-1:0];
                CFG_UNKNOWN_TYPE: r_unknown_type <= i_cfg_data[KIND_W-1:0];
                CFG_ENTRY_ZONE:   r_entry_zone   <= i_cfg_data[ZONE_W-1:0];
                CFG_DISCARD_ZONE: r_discard_zone <= i_cfg_data[ZONE_W-1:0];
                CFG_EJECTED_ZONE: r_ejected_zone <= i_cfg_data[ZONE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_box_id    = r_out_id;
    assign o_box_kind  = r_out_kind;
    assign o_zone      = r_out_zone;

    // an accepted event always starts a scan at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("scan did not start at slot zero");

    // the slot chosen by the search is still active at the update step
    a_found_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_found) |-> rd_entry.active)
        else $error("selected slot not active");

    // an allocation advances the ticket by one and never hands out id zero
    a_alloc_ctrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_alloc |=> (r_id_ctr != '0)
                     && (r_ticket_ctr == $past(r_ticket_ctr) + TICKET_W'(1)))
        else $error("counter update on allocation wrong");

    // a pending report is never overwritten by the update step
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && i_out_stall) |=> (r_state == ST_DONE))
        else $error("update step ran while output was stalled");

endmodule

`default_nettype wire

[sim/tb_conveyor_item_zone_tracker.sv]
// ----------------------------------------------------------------------------
// tb_conveyor_item_zone_tracker
// Drives new item, sensor and ejector events into the tracker and checks every
// report against a slot table kept alongside it. Covers several register
// settings, random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_conveyor_item_zone_tracker;
    import cizt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_EVENTS = 188;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [KIND_W-1:0] kind;
        logic [ZONE_W-1:0] zone;
    } t_report;

    // Slot table and counters as the block should hold them, plus the queue
    // of reports still owed by the block.
    class conveyor_table;
        bit [KIND_W-1:0]   none_type;
        bit [KIND_W-1:0]   unknown_type;
        bit [ZONE_W-1:0]   entry_zone;
        bit [ZONE_W-1:0]   discard_zone;
        bit [ZONE_W-1:0]   ejected_zone;
        bit                slot_active [SLOTS];
        bit [ID_W-1:0]     slot_ident  [SLOTS];
        bit [KIND_W-1:0]   slot_kind   [SLOTS];
        bit [ZONE_W-1:0]   slot_zone   [SLOTS];
        bit [TICKET_W-1:0] slot_ticket [SLOTS];
        bit [ID_W-1:0]     id_count;
        bit [TICKET_W-1:0] ticket_count;
        t_report           pending_reports[$];
        int                errors;

        function new();
            none_type    = 4'd0;
            unknown_type = 4'd1;
            entry_zone   = 3'd1;
            discard_zone = 3'd4;
            ejected_zone = 3'd5;
            for (int i = 0; i < SLOTS; i++) slot_active[i] = 1'b0;
            id_count     = '0;
            ticket_count = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NONE_TYPE:    none_type    = data;
                CFG_UNKNOWN_TYPE: unknown_type = data;
                CFG_ENTRY_ZONE:   entry_zone   = data[ZONE_W-1:0];
                CFG_DISCARD_ZONE: discard_zone = data[ZONE_W-1:0];
                CFG_EJECTED_ZONE: ejected_zone = data[ZONE_W-1:0];
                default: ;
            endcase
        endfunction

        // oldest active slot whose zone (by_zone) or kind matches key, -1 if none
        function int oldest_slot(bit by_zone, bit [KIND_W-1:0] key);
            int best;
            bit [TICKET_W-1:0] lowest;
            best   = -1;
            lowest = TICKET_MAX;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_active[i] && slot_ticket[i] < lowest &&
                    (by_zone ? ({1'b0, slot_zone[i]} == key) : (slot_kind[i] == key))) begin
                    lowest = slot_ticket[i];
                    best   = i;
                end
            end
            return best;
        endfunction

        function void note_event(logic [MODE_W-1:0] mode, logic [KIND_W-1:0] btype,
                                 logic [ZONE_W-1:0] sensor);
            int s;
            bit [ZONE_W-1:0] dest;
            case (mode)
                MODE_NEW: begin
                    if (btype != none_type) begin
                        s = -1;
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!slot_active[i]) s = i;
                        if (s >= 0) begin
                            id_count = id_count + 1'b1;
                            if (id_count == '0) id_count = ID_W'(1);
                            ticket_count   = ticket_count + 1'b1;
                            slot_active[s] = 1'b1;
                            slot_ident[s]  = id_count;
                            slot_kind[s]   = btype;
                            slot_zone[s]   = entry_zone;
                            slot_ticket[s] = ticket_count;
                            pending_reports.push_back({id_count, btype, entry_zone});
                        end
                    end
                end
                MODE_SENSOR: begin
                    dest = sensor + 1'b1;
                    s = oldest_slot(1'b1, {1'b0, sensor});
                    if (s >= 0) begin
                        slot_zone[s] = dest;
                        pending_reports.push_back({slot_ident[s], slot_kind[s], dest});
                        if (dest == discard_zone && slot_kind[s] == unknown_type)
                            slot_active[s] = 1'b0;
                    end
                end
                MODE_EJECT: begin
                    s = oldest_slot(1'b0, btype);
                    if (s >= 0) begin
                        pending_reports.push_back({slot_ident[s], slot_kind[s], ejected_zone});
                        slot_active[s] = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_report(logic [ID_W-1:0] ident, logic [KIND_W-1:0] kind,
                                   logic [ZONE_W-1:0] zone);
            t_report exp_rep;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: id %0d kind %0d zone %0d", ident, kind, zone);
            end else begin
                exp_rep = pending_reports.pop_front();
                if (exp_rep.ident !== ident || exp_rep.kind !== kind || exp_rep.zone !== zone) begin
                    errors++;
                    if (errors <= 10)
                        $display({"report mismatch: expected id %0d kind %0d zone %0d, ",
                                  "got id %0d kind %0d zone %0d"},
                                 exp_rep.ident, exp_rep.kind, exp_rep.zone, ident, kind, zone);
                end
            end
        endfunction

        function int active_count();
            int n;
            n = 0;
            for (int i = 0; i < SLOTS; i++) n += slot_active[i];
            return n;
        endfunction

        function int random_active_slot();
            int picks[$];
            for (int i = 0; i < SLOTS; i++)
                if (slot_active[i]) picks.push_back(i);
            if (picks.size() == 0) return -1;
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode      = MODE_NEW;
    logic [KIND_W-1:0]     i_box_type  = '0;
    logic [ZONE_W-1:0]     i_sensor_id = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ID_W-1:0]       o_box_id;
    logic [KIND_W-1:0]     o_box_kind;
    logic [ZONE_W-1:0]     o_zone;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    conveyor_table tracker = new();
    int  send_idle_pct  = 15;
    int  recv_idle_pct  = 75;
    bit  long_hold_req  = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_left      = 0;
    int  cycles         = 0;

    conveyor_item_zone_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_box_type  (i_box_type),
        .i_sensor_id (i_sensor_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_box_id    (o_box_id),
        .o_box_kind  (o_box_kind),
        .o_zone      (o_zone),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_conveyor_item_zone_tracker: errors");
            $finish;
        end
    end

    // report side: check each transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                tracker.check_report(o_box_id, o_box_kind, o_zone);
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic send_event(logic [MODE_W-1:0] mode, logic [KIND_W-1:0] btype,
                              logic [ZONE_W-1:0] sensor);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_box_type  <= btype;
        i_sensor_id <= sensor;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_event(mode, btype, sensor);
    endtask

    // mostly events that hit live items, with some noise mixed in
    task automatic send_random_event();
        int r, k, n;
        logic [MODE_W-1:0] mode;
        logic [KIND_W-1:0] btype;
        logic [ZONE_W-1:0] sensor;
        n      = tracker.active_count();
        k      = tracker.random_active_slot();
        r      = $urandom_range(0, 99);
        btype  = KIND_W'($urandom_range(0, 15));
        sensor = ZONE_W'($urandom_range(0, 7));
        if (r < 3) begin
            mode = MODE_UNUSED;
        end else if (r < ((n < SLOTS) ? 45 : 15)) begin
            mode = MODE_NEW;
        end else if (r < 72) begin
            mode = MODE_SENSOR;
            if (k >= 0 && $urandom_range(0, 4) != 0) sensor = tracker.slot_zone[k];
        end else begin
            mode = MODE_EJECT;
            if (k >= 0 && $urandom_range(0, 4) != 0) btype = tracker.slot_kind[k];
        end
        send_event(mode, btype, sensor);
    endtask

    // drop valid, wait for owed reports, then cover events that report nothing
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic program_registers(logic [CFG_DATA_W-1:0] v0, logic [CFG_DATA_W-1:0] v1,
                                     logic [CFG_DATA_W-1:0] v2, logic [CFG_DATA_W-1:0] v3,
                                     logic [CFG_DATA_W-1:0] v4);
        logic [CFG_IDX_W-1:0]  reg_idx [5];
        logic [CFG_DATA_W-1:0] reg_val [5];
        reg_idx = '{CFG_NONE_TYPE, CFG_UNKNOWN_TYPE, CFG_ENTRY_ZONE,
                    CFG_DISCARD_ZONE, CFG_EJECTED_ZONE};
        reg_val = '{v0, v1, v2, v3, v4};
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[r];
            i_cfg_data  <= reg_val[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.write_reg(reg_idx[r], reg_val[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored events, empty table, fill to full, discard, eject
        send_event(MODE_NEW, 4'd0, 3'd0);
        send_event(MODE_UNUSED, 4'd15, 3'd7);
        send_event(MODE_SENSOR, 4'd0, 3'd0);
        send_event(MODE_EJECT, 4'd15, 3'd0);
        send_event(MODE_NEW, 4'd1, 3'd0);            // slot 0 holds the unknown type
        for (int i = 2; i <= 15; i++) send_event(MODE_NEW, i[3:0], 3'd0);
        send_event(MODE_NEW, 4'd9, 3'd0);
        send_event(MODE_NEW, 4'd5, 3'd0);            // table full
        send_event(MODE_SENSOR, 4'd0, 3'd1);
        send_event(MODE_SENSOR, 4'd0, 3'd2);
        send_event(MODE_SENSOR, 4'd0, 3'd3);         // reaches discard zone, freed
        send_event(MODE_EJECT, 4'd15, 3'd0);
        send_event(MODE_NEW, 4'd15, 3'd0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: program_registers(4'd15, 4'd0, 4'd0, 4'd7, 4'd0);
                1: program_registers(4'd0, 4'd15, 4'd7, 4'd0, 4'd7);
                default: program_registers(CFG_DATA_W'($urandom_range(0, 15)),
                                           CFG_DATA_W'($urandom_range(0, 15)),
                                           CFG_DATA_W'($urandom_range(0, 15)),
                                           CFG_DATA_W'($urandom_range(0, 15)),
                                           CFG_DATA_W'($urandom_range(0, 15)));
            endcase
            case (p / 2)
                0: begin send_idle_pct = 15; recv_idle_pct <= 75; end
                1: begin send_idle_pct = 75; recv_idle_pct <= 15; end
                default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
            endcase
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (p == 4 && n == 20) long_hold_req <= 1'b1;
                send_random_event();
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
            $display("tb_conveyor_item_zone_tracker: clean");
        else
            $display("tb_conveyor_item_zone_tracker: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/cizt_pkg.sv
rtl/core/cizt_slot_table.sv
rtl/core/conveyor_item_zone_tracker.sv
sim/tb_conveyor_item_zone_tracker.sv
